/* rtl/core/sac_pkg.sv */
// Package for the stick axis conditioner: register indexes, widths, defaults and
// the command and status types between the controller and the datapath.
// No dependencies.
package sac_pkg;

  localparam int AXIS_FRAC_BITS_DEF = 23;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOUSE_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECENTER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 3'd5;

  localparam logic [15:0] RAMP_UP_RST = 16'd2048;
  localparam logic [15:0] RAMP_DOWN_RST = 16'd2048;
  localparam logic [15:0] MOUSE_GAIN_RST = 16'd1024;
  localparam logic [15:0] SMOOTH_RST = 16'd32768;
  localparam logic [15:0] RECENTER_RST = 16'd2048;
  localparam logic [14:0] DEAD_BAND_RST = 15'd3277;
  localparam logic [14:0] DEAD_BAND_CAP = 15'd31129;

  localparam logic [63:0] SQRT_HALF_Q32 = 64'd3037000500;

  localparam logic [1:0] AX_LX = 2'd0;
  localparam logic [1:0] AX_LY = 2'd1;
  localparam logic [1:0] AX_RX = 2'd2;
  localparam logic [1:0] AX_RY = 2'd3;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_UP,
    MUL_DN,
    MUL_RC,
    MUL_DX,
    MUL_DY,
    MUL_LVS,
    MUL_TGS,
    MUL_SHP
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WB_UP,
    OP_WB_DN,
    OP_WB_RC,
    OP_WB_MX,
    OP_WB_MY,
    OP_HOLD,
    OP_BLEND,
    OP_LEFT,
    OP_RECENTER,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DIVEND
  } op_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     load_out;
    mul_sel_t mul_sel;
    op_sel_t  op_sel;
    logic [1:0] ax;
  } sac_cmd_t;

  typedef struct packed {
    logic mouse_moved;
  } sac_stat_t;

endpackage

/* rtl/core/stick_axis_conditioner.sv */
// Stick axis conditioner top level: keys and mouse deltas to two conditioned sticks.
// Takes one request at a time and no new one until the current result is loaded to the output;
// most of the work is the 16-step output divider that runs once for each of the four axes.
// A new request is taken while the previous result waits at the output.
// Synchronous active-low reset restores register defaults and zeroes all levels.
// Instantiates sac_ctrl and sac_datapath; depends on sac_pkg.
module stick_axis_conditioner #(
  parameter int AXIS_FRAC_BITS = sac_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_left_neg_key,
  input  logic                           in_left_pos_key,
  input  logic                           in_down_neg_key,
  input  logic                           in_up_pos_key,
  input  logic signed [15:0]             in_mouse_dx,
  input  logic signed [15:0]             in_mouse_dy,
  input  logic [15:0]                    in_frame_time,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_left_x_out,
  output logic signed [15:0]             out_left_y_out,
  output logic signed [15:0]             out_right_x_out,
  output logic signed [15:0]             out_right_y_out
);
  import sac_pkg::*;

  sac_cmd_t cmd;
  sac_stat_t stat;

  assign cfg_ready = 1'b1;

  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sac_datapath #(
    .AXIS_FRAC_BITS(AXIS_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_left_neg_key (in_left_neg_key),
    .in_left_pos_key (in_left_pos_key),
    .in_down_neg_key (in_down_neg_key),
    .in_up_pos_key   (in_up_pos_key),
    .in_mouse_dx     (in_mouse_dx),
    .in_mouse_dy     (in_mouse_dy),
    .in_frame_time   (in_frame_time),
    .cmd             (cmd),
    .stat            (stat),
    .out_left_x_out  (out_left_x_out),
    .out_left_y_out  (out_left_y_out),
    .out_right_x_out (out_right_x_out),
    .out_right_y_out (out_right_y_out)
  );

endmodule

/* rtl/core/sac_ctrl.sv */
// Controller of the stick axis conditioner: sequences the shared multiplier,
// the stick updates and the per-axis output divider. Depends on sac_pkg.
module sac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sac_pkg::sac_stat_t stat,
  output sac_pkg::sac_cmd_t  cmd
);
  import sac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_MOUSE,
    S_RECEN,
    S_SHP_MUL,
    S_SHP_INIT,
    S_DIV,
    S_DIV_END,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ax_nxt = ax_r;
    out_valid_nxt = out_valid_r;
    cmd = '{load_in: 1'b0, load_out: 1'b0, mul_sel: MUL_NONE, op_sel: OP_NONE, ax: ax_r};
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_PRE;
          cnt_nxt = 4'd0;
        end
      end
      S_PRE: begin
        cnt_nxt = cnt_r + 4'd1;
        case (cnt_r)
          4'd0: cmd.mul_sel = MUL_UP;
          4'd1: begin
            cmd.mul_sel = MUL_DN;
            cmd.op_sel = OP_WB_UP;
          end
          4'd2: begin
            cmd.mul_sel = MUL_RC;
            cmd.op_sel = OP_WB_DN;
          end
          4'd3: begin
            cmd.mul_sel = MUL_DX;
            cmd.op_sel = OP_WB_RC;
          end
          4'd4: begin
            cmd.mul_sel = MUL_DY;
            cmd.op_sel = OP_WB_MX;
          end
          4'd5: cmd.op_sel = OP_WB_MY;
          4'd6: begin
            cmd.op_sel = OP_LEFT;
            cmd.ax = AX_LX;
          end
          default: begin
            cmd.op_sel = OP_LEFT;
            cmd.ax = AX_LY;
            cnt_nxt = 4'd0;
            state_nxt = stat.mouse_moved ? S_MOUSE : S_RECEN;
          end
        endcase
      end
      S_MOUSE: begin
        cnt_nxt = cnt_r + 4'd1;
        cmd.ax = (cnt_r < 4'd3) ? AX_RX : AX_RY;
        case (cnt_r)
          4'd0, 4'd3: cmd.mul_sel = MUL_LVS;
          4'd1, 4'd4: begin
            cmd.mul_sel = MUL_TGS;
            cmd.op_sel = OP_HOLD;
          end
          4'd2: cmd.op_sel = OP_BLEND;
          default: begin
            cmd.op_sel = OP_BLEND;
            cnt_nxt = 4'd0;
            ax_nxt = AX_LX;
            state_nxt = S_SHP_MUL;
          end
        endcase
      end
      S_RECEN: begin
        cmd.op_sel = OP_RECENTER;
        cmd.ax = (cnt_r == 4'd0) ? AX_RX : AX_RY;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r != 4'd0) begin
          cnt_nxt = 4'd0;
          ax_nxt = AX_LX;
          state_nxt = S_SHP_MUL;
        end
      end
      S_SHP_MUL: begin
        cmd.mul_sel = MUL_SHP;
        state_nxt = S_SHP_INIT;
      end
      S_SHP_INIT: begin
        cmd.op_sel = OP_DIVINIT;
        cnt_nxt = 4'd0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op_sel = OP_DIVSTEP;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd.op_sel = OP_DIVEND;
        ax_nxt = ax_r + 2'd1;
        state_nxt = (ax_r == AX_RY) ? S_FINISH : S_SHP_MUL;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= 4'd0;
      ax_r <= AX_LX;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ax_r <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/sac_datapath.sv */
// Datapath of the stick axis conditioner: configuration registers, stick levels,
// one shared multiplier, ramp and blend logic and a restoring divider.
// Depends on sac_pkg.
module sac_datapath #(
  parameter int AXIS_FRAC_BITS = sac_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sac_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_left_neg_key,
  input  logic                             in_left_pos_key,
  input  logic                             in_down_neg_key,
  input  logic                             in_up_pos_key,
  input  logic signed [15:0]               in_mouse_dx,
  input  logic signed [15:0]               in_mouse_dy,
  input  logic [15:0]                      in_frame_time,
  input  sac_pkg::sac_cmd_t                cmd,
  output sac_pkg::sac_stat_t               stat,
  output logic signed [15:0]               out_left_x_out,
  output logic signed [15:0]               out_left_y_out,
  output logic signed [15:0]               out_right_x_out,
  output logic signed [15:0]               out_right_y_out
);
  import sac_pkg::*;

  localparam int F = AXIS_FRAC_BITS;
  localparam int LW = F + 2;
  localparam int PW = LW + 18;
  localparam int DW = F + 18;
  localparam logic [63:0] ONE64 = 64'd1 << F;
  localparam logic [LW-1:0] ONE = LW'(ONE64);
  localparam logic [63:0] DIAG64 = (SQRT_HALF_Q32 * ONE64 + 64'd2147483648) >> 32;
  localparam logic [LW-1:0] DIAG = LW'(DIAG64);
  localparam int SSHL = (F >= 24) ? F - 24 : 0;
  localparam int SSHR = (F >= 24) ? 0 : 24 - F;
  localparam logic [63:0] SRND = (SSHR > 0) ? (64'd1 << (SSHR - 1)) : 64'd0;
  localparam int MSHL = (F >= 16) ? F - 16 : 0;
  localparam int MSHR = (F >= 16) ? 0 : 16 - F;
  localparam logic [63:0] MRND = (MSHR > 0) ? (64'd1 << (MSHR - 1)) : 64'd0;
  localparam logic [63:0] STEP_MAX = (64'd1 << LW) - 64'd1;

  logic [15:0] ramp_up_r, ramp_dn_r, gain_r, smooth_r, recen_r;
  logic [14:0] dead_band_r;
  logic kln_r, klp_r, kdn_r, kup_r;
  logic signed [15:0] dx_r, dy_r;
  logic [15:0] t_r;
  logic signed [LW-1:0] lev_r [4];
  logic signed [LW-1:0] lev_nxt;
  logic [LW-1:0] step_up_r, step_dn_r, step_rc_r, step_cv;
  logic signed [LW-1:0] mx_r, my_r, mouse_cv, blend_cv;
  logic signed [PW-1:0] prod_r;
  logic signed [63:0] hold_r;
  logic signed [LW-1:0] mul_a;
  logic signed [17:0] mul_b;
  logic zero_r, neg_r;
  logic [DW-1:0] rem_r, dvs_r;
  logic [15:0] q_r;
  logic signed [15:0] res_r [4];

  logic signed [LW-1:0] cur;
  logic [LW-1:0] cur_mag, dead_w, shp_mag;
  logic signed [63:0] p64;

  assign stat.mouse_moved = (dx_r != 16'sd0) || (dy_r != 16'sd0);
  assign cur = lev_r[cmd.ax];
  assign cur_mag = cur[LW-1] ? LW'(-cur) : LW'(cur);
  assign dead_w = LW'({49'd0, dead_band_r} << (F - 15));
  assign shp_mag = cur_mag - dead_w;
  assign p64 = 64'(prod_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_UP: begin
        mul_a = signed'(LW'(ramp_up_r));
        mul_b = signed'({2'b00, t_r});
      end
      MUL_DN: begin
        mul_a = signed'(LW'(ramp_dn_r));
        mul_b = signed'({2'b00, t_r});
      end
      MUL_RC: begin
        mul_a = signed'(LW'(recen_r));
        mul_b = signed'({2'b00, t_r});
      end
      MUL_DX: begin
        mul_a = LW'(dx_r);
        mul_b = signed'({2'b00, gain_r});
      end
      MUL_DY: begin
        mul_a = -LW'(dy_r);
        mul_b = signed'({2'b00, gain_r});
      end
      MUL_LVS: begin
        mul_a = cur;
        mul_b = signed'({2'b00, smooth_r});
      end
      MUL_TGS: begin
        mul_a = (cmd.ax == AX_RX) ? mx_r : my_r;
        mul_b = 18'sd65536 - signed'({2'b00, smooth_r});
      end
      MUL_SHP: begin
        mul_a = signed'(shp_mag);
        mul_b = cur[LW-1] ? 18'sd32768 : 18'sd32767;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    logic [63:0] w;
    w = (F >= 24) ? (64'(prod_r) << SSHL) : ((64'(prod_r) + SRND) >> SSHR);
    step_cv = (w > STEP_MAX) ? LW'(STEP_MAX) : LW'(w);
  end

  always_comb begin
    logic [63:0] m, mm;
    m = p64[63] ? 64'(-p64) : 64'(p64);
    mm = (F >= 16) ? (m << MSHL) : ((m + MRND) >> MSHR);
    if (mm > ONE64) begin
      mm = ONE64;
    end
    mouse_cv = p64[63] ? -LW'(mm) : LW'(mm);
  end

  always_comb begin
    logic signed [63:0] sum;
    logic [63:0] m, mm;
    sum = hold_r + p64;
    m = sum[63] ? 64'(-sum) : 64'(sum);
    mm = (m + 64'd32768) >> 16;
    if (mm > ONE64) begin
      mm = ONE64;
    end
    blend_cv = sum[63] ? -LW'(mm) : LW'(mm);
  end

  always_comb begin
    logic signed [1:0] tk;
    logic both;
    logic signed [LW-1:0] tgt;
    logic [LW-1:0] tmag, stp;
    logic signed [LW+1:0] c2, t2, s2, n2;
    both = (klp_r != kln_r) && (kup_r != kdn_r);
    if (cmd.ax == AX_LX) begin
      tk = signed'({1'b0, klp_r}) - signed'({1'b0, kln_r});
    end else begin
      tk = signed'({1'b0, kup_r}) - signed'({1'b0, kdn_r});
    end
    tmag = both ? DIAG : ONE;
    if (tk == 2'sd0 || cmd.op_sel == OP_RECENTER) begin
      tgt = '0;
      tmag = '0;
    end else if (tk < 2'sd0) begin
      tgt = -signed'(tmag);
    end else begin
      tgt = signed'(tmag);
    end
    if (cmd.op_sel == OP_RECENTER) begin
      stp = step_rc_r;
    end else begin
      stp = (tmag > cur_mag) ? step_up_r : step_dn_r;
    end
    c2 = (LW+2)'(cur);
    t2 = (LW+2)'(tgt);
    s2 = signed'({2'b00, stp});
    if (c2 < t2) begin
      n2 = c2 + s2;
      if (n2 > t2) begin
        n2 = t2;
      end
    end else begin
      n2 = c2 - s2;
      if (n2 < t2) begin
        n2 = t2;
      end
    end
    lev_nxt = LW'(n2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_up_r <= RAMP_UP_RST;
      ramp_dn_r <= RAMP_DOWN_RST;
      gain_r <= MOUSE_GAIN_RST;
      smooth_r <= SMOOTH_RST;
      recen_r <= RECENTER_RST;
      dead_band_r <= DEAD_BAND_RST;
      for (int i = 0; i < 4; i++) begin
        lev_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RAMP_UP: ramp_up_r <= cfg_data;
          REG_RAMP_DOWN: ramp_dn_r <= cfg_data;
          REG_MOUSE_GAIN: gain_r <= cfg_data;
          REG_SMOOTH: smooth_r <= cfg_data;
          REG_RECENTER: recen_r <= cfg_data;
          REG_DEAD_BAND: begin
            dead_band_r <= (cfg_data[14:0] > DEAD_BAND_CAP) ? DEAD_BAND_CAP : cfg_data[14:0];
          end
          default: begin
          end
        endcase
      end
      case (cmd.op_sel)
        OP_BLEND: lev_r[cmd.ax] <= blend_cv;
        OP_LEFT, OP_RECENTER: lev_r[cmd.ax] <= lev_nxt;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kln_r <= in_left_neg_key;
      klp_r <= in_left_pos_key;
      kdn_r <= in_down_neg_key;
      kup_r <= in_up_pos_key;
      dx_r <= in_mouse_dx;
      dy_r <= in_mouse_dy;
      t_r <= in_frame_time;
    end
    prod_r <= PW'(mul_a) * PW'(mul_b);
    if (cmd.mul_sel == MUL_SHP) begin
      zero_r <= cur_mag < dead_w;
      neg_r <= cur[LW-1];
    end
    case (cmd.op_sel)
      OP_WB_UP: step_up_r <= step_cv;
      OP_WB_DN: step_dn_r <= step_cv;
      OP_WB_RC: step_rc_r <= step_cv;
      OP_WB_MX: mx_r <= mouse_cv;
      OP_WB_MY: my_r <= mouse_cv;
      OP_HOLD: hold_r <= p64;
      OP_DIVINIT: begin
        rem_r <= DW'({p64[62:0], 1'b0}) + DW'(ONE - dead_w);
        dvs_r <= DW'(ONE - dead_w) << 16;
        q_r <= '0;
      end
      OP_DIVSTEP: begin
        if (rem_r >= dvs_r) begin
          rem_r <= rem_r - dvs_r;
          q_r <= {q_r[14:0], 1'b1};
        end else begin
          q_r <= {q_r[14:0], 1'b0};
        end
        dvs_r <= dvs_r >> 1;
      end
      OP_DIVEND: begin
        res_r[cmd.ax] <= zero_r ? 16'sd0 : (neg_r ? -signed'(q_r) : signed'(q_r));
      end
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_left_x_out <= res_r[0];
      out_left_y_out <= res_r[1];
      out_right_x_out <= res_r[2];
      out_right_y_out <= res_r[3];
    end
  end

endmodule
